>>> rtl/cse_pkg.sv
package cse_pkg;

  localparam int MAX_DEGREE_DEF = 63;
  localparam int DEG_W          = 6;
  localparam int IDX_W          = 6;
  localparam int COEF_W         = 32;
  localparam int POINT_W        = 32;
  localparam int SUM_W          = 40;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_SERIES_DEGREE = 1'b0;

  // 1.0 in Q1.30
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C0,
    ST_TMUL,
    ST_ACCX,
    ST_REC,
    ST_DONE
  } cse_state_t;

endpackage

>>> rtl/cse_in_if.sv
interface cse_in_if;
  import cse_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [IDX_W-1:0]          coef_index;
  logic signed [COEF_W-1:0]  coef_value;
  logic signed [POINT_W-1:0] eval_point;

  modport source (output valid, cmd, coef_index, coef_value, eval_point, input ready);
  modport sink   (input valid, cmd, coef_index, coef_value, eval_point, output ready);
endinterface

>>> rtl/cse_out_if.sv
interface cse_out_if;
  import cse_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] series_value;
  logic                    saturated;

  modport source (output valid, series_value, saturated, input ready);
  modport sink   (input valid, series_value, saturated, output ready);
endinterface

>>> rtl/cse_coef_mem.sv
module cse_coef_mem #(
  parameter int DEPTH = cse_pkg::MAX_DEGREE_DEF + 1,
  parameter int AW    = (DEPTH < 3) ? 1 : $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              wr_addr,
  input  logic [cse_pkg::COEF_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [cse_pkg::COEF_W-1:0] rd_data
);
  import cse_pkg::*;

  logic [COEF_W-1:0] mem [DEPTH];
  logic [COEF_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // addresses past DEPTH only occur on a look-ahead read whose data is dropped
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/chebyshev_series_evaluator_unit.sv
// Evaluates sum c_j*T_j(x) for j = 0..d with the recurrence T_j = 2x*T_{j-1} - T_{j-2}, where
// d = min(series_degree, MAX_DEGREE). A word with cmd = 0 stores coef_value (Q8.24) in slot
// coef_index and gives no result; slots above MAX_DEGREE are dropped. A word with cmd = 1
// evaluates at eval_point (Q1.30, clipped to [-1,1]) and gives one Q16.24 result with a saturation
// flag. The next word can be taken in the same cycle as the result appears. One 32x32 multiplier
// is shared by the two products of every term above c_0, so each such term costs a coefficient
// multiply, an accumulate that also issues the recurrence multiply, and a recurrence update that
// the last term skips. The block takes no new word while an evaluation runs, and an evaluation
// that ends while an earlier result still waits in the output register holds until it is taken.
// Every coefficient up to d must be written before it is used. series_degree sits at byte
// address 0 of the APB port; pready is always high.
module chebyshev_series_evaluator_unit #(
  parameter int MAX_DEGREE = cse_pkg::MAX_DEGREE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cse_in_if.sink                     in_ch,
  cse_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cse_pkg::APB_AW-1:0] paddr,
  input  logic [cse_pkg::APB_DW-1:0] pwdata,
  output logic [cse_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import cse_pkg::*;

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int AW    = (DEPTH < 3) ? 1 : $clog2(DEPTH);
  localparam int EXT_W = 11;
  localparam int ACC_W = 42;

  // configuration
  logic [DEG_W-1:0] degree_r;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SERIES_DEGREE);
  assign prdata = (paddr[2] == REG_SERIES_DEGREE) ?
                  {{(APB_DW-DEG_W){1'b0}}, degree_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
    end else if (cfg_we) begin
      degree_r <= pwdata[DEG_W-1:0];
    end
  end

  // control and datapath registers
  cse_state_t              state_r, state_nxt;
  logic [DEG_W-1:0]        deg_r, deg_nxt;
  logic [DEG_W-1:0]        j_r, j_nxt;
  logic signed [31:0]      x_r, x_nxt;
  logic signed [31:0]      tm1_r, tm1_nxt;
  logic signed [31:0]      tm2_r, tm2_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [63:0]      prod_r, prod_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_value_r, out_value_nxt;
  logic                    out_sat_r, out_sat_nxt;

  logic signed [31:0]      mul_a, mul_b;
  logic [AW-1:0]           rd_addr;
  logic [COEF_W-1:0]       rd_data;
  logic                    mem_we;
  logic [AW-1:0]           wr_addr;
  logic                    idx_ok;
  logic [EXT_W-1:0]        idx_ext, deg_ext, jp1_ext;
  logic [DEG_W-1:0]        deg_eff;
  logic signed [31:0]      x_clip;
  logic signed [63:0]      term_sum, rec_sum;
  logic signed [33:0]      term;
  logic signed [32:0]      rec_round;
  logic signed [33:0]      rec_diff;
  logic signed [31:0]      rec_clip;
  logic                    acc_hi, acc_lo;

  assign idx_ext = {{(EXT_W-IDX_W){1'b0}}, in_ch.coef_index};
  assign deg_ext = {{(EXT_W-DEG_W){1'b0}}, degree_r};
  assign jp1_ext = {{(EXT_W-DEG_W){1'b0}}, j_r} + EXT_W'(1);
  assign idx_ok  = idx_ext <= EXT_W'(MAX_DEGREE);
  assign wr_addr = idx_ext[AW-1:0];
  assign deg_eff = (deg_ext > EXT_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_r;
  assign mem_we  = in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_WRITE) && idx_ok;

  always_comb begin
    if (in_ch.eval_point > Q30_ONE) begin
      x_clip = Q30_ONE;
    end else if (in_ch.eval_point < -Q30_ONE) begin
      x_clip = -Q30_ONE;
    end else begin
      x_clip = in_ch.eval_point;
    end
  end

  // c_j*T_j rounded to Q.24, half up
  assign term_sum = prod_r + 64'sd536870912;
  assign term     = term_sum[63:30];

  // 2*x*T_{j-1} rounded to Q1.30 is (x*T_{j-1} + 2^28) >> 29
  assign rec_sum   = prod_r + 64'sd268435456;
  assign rec_round = rec_sum[61:29];
  assign rec_diff  = {rec_round[32], rec_round} - {{2{tm2_r[31]}}, tm2_r};

  always_comb begin
    if (rec_diff > 34'sh0_4000_0000) begin
      rec_clip = Q30_ONE;
    end else if (rec_diff < -34'sh0_4000_0000) begin
      rec_clip = -Q30_ONE;
    end else begin
      rec_clip = rec_diff[31:0];
    end
  end

  assign acc_hi = !acc_r[ACC_W-1] && (acc_r[ACC_W-2:SUM_W-1] != '0);
  assign acc_lo = acc_r[ACC_W-1] && (acc_r[ACC_W-2:SUM_W-1] != '1);

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    state_nxt     = state_r;
    deg_nxt       = deg_r;
    j_nxt         = j_r;
    x_nxt         = x_r;
    tm1_nxt       = tm1_r;
    tm2_nxt       = tm2_r;
    acc_nxt       = acc_r;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mul_a         = x_r;
    mul_b         = tm1_r;
    rd_addr       = jp1_ext[AW-1:0];
    in_ch.ready   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        rd_addr     = '0;
        if (in_ch.valid && (in_ch.cmd == CMD_EVAL)) begin
          x_nxt     = x_clip;
          deg_nxt   = deg_eff;
          state_nxt = ST_C0;
        end
      end
      ST_C0: begin
        rd_addr = AW'(1);
        acc_nxt = ACC_W'(signed'(rd_data));
        if (deg_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          tm2_nxt   = Q30_ONE;
          tm1_nxt   = x_r;
          j_nxt     = DEG_W'(1);
          state_nxt = ST_TMUL;
        end
      end
      ST_TMUL: begin
        rd_addr   = j_r[AW-1:0];
        mul_a     = signed'(rd_data);
        state_nxt = ST_ACCX;
      end
      ST_ACCX: begin
        // product register takes x*T_j here for the next recurrence step
        acc_nxt = acc_r + {{(ACC_W-34){term[33]}}, term};
        if (j_r == deg_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_REC;
        end
      end
      ST_REC: begin
        tm2_nxt   = tm1_r;
        tm1_nxt   = rec_clip;
        j_nxt     = j_r + DEG_W'(1);
        state_nxt = ST_TMUL;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (acc_hi) begin
            out_value_nxt = {1'b0, {(SUM_W-1){1'b1}}};
            out_sat_nxt   = 1'b1;
          end else if (acc_lo) begin
            out_value_nxt = {1'b1, {(SUM_W-1){1'b0}}};
            out_sat_nxt   = 1'b1;
          end else begin
            out_value_nxt = acc_r[SUM_W-1:0];
            out_sat_nxt   = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deg_r       <= deg_nxt;
    j_r         <= j_nxt;
    x_r         <= x_nxt;
    tm1_r       <= tm1_nxt;
    tm2_r       <= tm2_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.series_value = out_value_r;
  assign out_ch.saturated    = out_sat_r;

  cse_coef_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_coef_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (wr_addr),
    .wr_data (in_ch.coef_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

>>> verif/chebyshev_series_evaluator_unit_test.sv
typedef struct {
  logic signed [cse_pkg::SUM_W-1:0] value;
  logic                             sat;
} series_result_t;

localparam longint SUM_HI = (64'sd1 <<< 39) - 64'sd1;
localparam longint SUM_LO = -(64'sd1 <<< 39);

// Keeps a shadow of the coefficient store and the degree, and the queue of
// series values still owed by the block.
class series_tracker;
  logic signed [cse_pkg::COEF_W-1:0] coef [64];
  bit                                written [64];
  logic [cse_pkg::DEG_W-1:0]         degree = '0;
  series_result_t                    owed [$];
  int                                errors;

  function longint clip_unit(longint v);
    longint unit;
    unit = longint'(cse_pkg::Q30_ONE);
    if (v > unit) return unit;
    if (v < -unit) return -unit;
    return v;
  endfunction

  // drop 30 fraction bits, ties go toward +inf
  function longint round_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function series_result_t series_sum(logic signed [cse_pkg::POINT_W-1:0] point);
    series_result_t r;
    longint x, t_prev2, t_prev1, t_cur, acc, cj;
    x = clip_unit(longint'(point));
    acc = longint'(coef[0]);
    if (degree != 0) begin
      t_prev2 = longint'(cse_pkg::Q30_ONE);
      t_prev1 = x;
      cj = longint'(coef[1]);
      acc += round_q30(cj * x);
      for (int j = 2; j <= int'(degree); j++) begin
        t_cur = clip_unit(round_q30(2 * x * t_prev1) - t_prev2);
        t_prev2 = t_prev1;
        t_prev1 = t_cur;
        cj = longint'(coef[j]);
        acc += round_q30(cj * t_cur);
      end
    end
    r.sat = 1'b0;
    if (acc > SUM_HI) begin
      acc = SUM_HI;
      r.sat = 1'b1;
    end else if (acc < SUM_LO) begin
      acc = SUM_LO;
      r.sat = 1'b1;
    end
    r.value = acc[cse_pkg::SUM_W-1:0];
    return r;
  endfunction

  function void note_word(logic cmd, logic [cse_pkg::IDX_W-1:0] idx,
                          logic signed [cse_pkg::COEF_W-1:0] value,
                          logic signed [cse_pkg::POINT_W-1:0] point);
    if (cmd == cse_pkg::CMD_WRITE) begin
      coef[idx] = value;
      written[idx] = 1'b1;
    end else begin
      owed.push_back(series_sum(point));
    end
  endfunction

  function void check_result(logic signed [cse_pkg::SUM_W-1:0] value, logic sat);
    series_result_t want;
    if (owed.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual value %0d sat %0b",
               $time, value, sat);
      errors++;
      return;
    end
    want = owed.pop_front();
    if (value !== want.value) begin
      $display("%0t: series_value mismatch, expected %0d, actual %0d",
               $time, want.value, value);
      errors++;
    end
    if (sat !== want.sat) begin
      $display("%0t: saturated mismatch, expected %0b, actual %0b", $time, want.sat, sat);
      errors++;
    end
  endfunction
endclass

module chebyshev_series_evaluator_unit_test;
  import cse_pkg::*;

  localparam logic [APB_AW-1:0] DEGREE_ADDR  = {REG_SERIES_DEGREE, 2'b00};
  localparam logic [APB_AW-1:0] SPARE_ADDR   = {~REG_SERIES_DEGREE, 2'b00};
  localparam int                HOLD_CYCLES  = 400;
  localparam int                SETTLE_CYCLES = 8;
  localparam int                TAIL_CYCLES  = 250;
  localparam int                RANDOM_WORDS = 1050;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cse_in_if  in_ch ();
  cse_out_if out_ch ();

  series_tracker tracker = new;
  bit            hold_output;
  int            in_calm;
  int            out_calm;

  chebyshev_series_evaluator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("chebyshev_series_evaluator_unit test failed");
    $finish;
  end

  // wait drawn per word; now and then a run of back-to-back words
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POINT_W-1:0] rand_point();
    logic [POINT_W-1:0] p;
    case ($urandom_range(0, 11))
      0: p = 32'h4000_0000;
      1: p = 32'hC000_0000;
      2: p = 32'h7FFF_FFFF;
      3: p = 32'h8000_0000;
      4, 5: p = $urandom;
      default: p = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
    return p;
  endfunction

  task automatic send_word(logic cmd, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] value,
                           logic [POINT_W-1:0] point);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= value;
    in_ch.eval_point <= point;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_word(cmd, idx, value, point);
  endtask

  task automatic send_eval(logic [POINT_W-1:0] point);
    send_word(CMD_EVAL, IDX_W'($urandom), $urandom, point);
  endtask

  task automatic send_coef(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] value);
    send_word(CMD_WRITE, idx, value, $urandom);
  endtask

  // block must be idle before a register write
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == DEGREE_ADDR) tracker.degree = data[DEG_W-1:0];
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_output) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      tracker.check_result(out_ch.series_value, out_ch.saturated);
    end
  end

  initial begin
    logic [POINT_W-1:0] corner_points [9];
    logic [APB_DW-1:0]  deg_word;
    int                 d;
    int                 sent;
    int                 span;
    bit                 pressed;

    corner_points = '{32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                      32'h1, 32'hFFFF_FFFF, 32'h4000_0001, 32'hBFFF_FFFF};
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_WRITE;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    in_ch.eval_point <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degree zero after reset: result is c0 as is
    send_coef(IDX_W'(0), 32'h7FFF_FFFF);
    send_eval(32'h0);
    send_coef(IDX_W'(0), 32'h8000_0000);
    send_eval(32'h8000_0000);
    send_coef(IDX_W'(1), 32'h8000_0000);
    send_coef(IDX_W'(2), 32'h7FFF_FFFF);
    send_coef(IDX_W'(3), $urandom);
    send_coef(IDX_W'(63), 32'h8000_0000);
    drain();
    write_reg(DEGREE_ADDR, 32'd3);
    write_reg(SPARE_ADDR, 32'hFFFF_FFFF);  // no such register, degree stays 3
    foreach (corner_points[k]) send_eval(corner_points[k]);

    sent = 0;
    pressed = 1'b0;
    while (sent < RANDOM_WORDS) begin
      drain();
      case ($urandom_range(0, 9))
        0: d = 0;
        1: d = 63;
        default: d = $urandom_range(1, 12);
      endcase
      deg_word = ($urandom_range(0, 3) == 0) ? ($urandom & ~32'h3F) : '0;
      write_reg(DEGREE_ADDR, deg_word | APB_DW'(d));
      if ($urandom_range(0, 7) == 0) write_reg(SPARE_ADDR, $urandom);
      // every slot the sum will read gets loaded first
      for (int j = 0; j <= d; j++) begin
        if (!tracker.written[j]) begin
          send_coef(IDX_W'(j), rand_coef());
          sent++;
        end
      end
      if (!pressed) begin
        // output held off while evaluations keep coming: input must back up
        pressed = 1'b1;
        hold_output = 1'b1;
        repeat (8) send_eval(rand_point());
        sent += 8;
      end
      span = $urandom_range(10, 60);
      repeat (span) begin
        if ($urandom_range(0, 1) == 0) begin
          send_eval(rand_point());
        end else if ($urandom_range(0, 9) < 7) begin
          send_coef(IDX_W'($urandom_range(0, d)), rand_coef());
        end else begin
          send_coef(IDX_W'($urandom), rand_coef());
        end
        sent++;
      end
    end

    in_ch.valid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("chebyshev_series_evaluator_unit test passed");
    end else begin
      $display("chebyshev_series_evaluator_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cse_pkg.sv
rtl/cse_in_if.sv
rtl/cse_out_if.sv
rtl/cse_coef_mem.sv
rtl/chebyshev_series_evaluator_unit.sv
verif/chebyshev_series_evaluator_unit_test.sv
